>>> rtl/wrf_pkg.sv
`default_nettype none
package wrf_pkg;
  localparam int unsigned NumSections = 4;
  localparam int unsigned MaxPoints   = 4;
  localparam int unsigned FracBits    = 12;
  localparam int unsigned SecW  = 2;
  localparam int unsigned PtW   = 2;
  localparam int unsigned CntW  = 3;
  localparam int unsigned PosW  = 24;
  localparam int unsigned StepW = 16;
  localparam int unsigned TolW  = 20;
  localparam int unsigned AddrW = SecW + PtW;
  localparam int unsigned Depth = NumSections * MaxPoints;
  // Squared distance needs 2*(PosW+1)+1 bits.
  localparam int unsigned SumW  = 2 * (PosW + 1) + 1;
  localparam int unsigned RootW = (SumW + 1) / 2;
  localparam int unsigned MagW  = PosW + 1;
  localparam int unsigned ProdW = StepW + MagW;

  localparam logic [StepW-1:0] StepReset = StepW'((1 << FracBits) / 5);
  localparam logic [TolW-1:0]  TolReset  = TolW'(5 << FracBits);

  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdPlace = 2'd2;

  localparam logic [1:0] RegTarget = 2'd0;
  localparam logic [1:0] RegStep   = 2'd1;
  localparam logic [1:0] RegTol    = 2'd2;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [SecW-1:0]        section_sel;
    logic [PtW-1:0]         point_sel;
    logic signed [PosW-1:0] coord_x;
    logic signed [PosW-1:0] coord_y;
    logic                   final_point;
  } in_req_t;

  typedef struct packed {
    logic                   moving;
    logic signed [PosW-1:0] pos_x_out;
    logic signed [PosW-1:0] pos_y_out;
    logic [SecW-1:0]        section_out;
    logic [PtW-1:0]         waypoint_out;
  } out_req_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load_in;     // capture the request
    logic do_write;    // write waypoint store and count
    logic do_place;    // set position and current waypoint
    logic pick_next;   // select next waypoint, issue RAM read
    logic calc_dist;   // compute dx, dy, squared sum
    logic adopt;       // move current waypoint to the next one
    logic sqrt_start;
    logic div_start;   // start the two divisions
    logic do_step;     // add the steps to the position
    logic set_moving;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic       is_last;   // current is last of target section
    logic       far;       // squared distance above tolerance squared
    logic       sqrt_done;
    logic       div_done;
  } sts_t;
endpackage
`default_nettype wire

>>> rtl/waypoint_route_follower.sv
`default_nettype none
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid/in_ready    | in_req_t
// out     | output    | out_valid/out_ready  | out_req_t
// cfg     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
// Write, place and arrival go straight to output; a waypoint adopt also reads and compares.
// A step further runs a bitwise square root, then two parallel dividers.
// Reset clears position and current waypoint, sets each section count to one and loads register defaults.
// A waiting result holds in the output register; the next request is taken meanwhile.
module waypoint_route_follower
  import wrf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_req_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_req_t        out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  ctl_t ctl;
  sts_t sts;
  logic [SecW-1:0]  target_q;
  logic [StepW-1:0] step_q;
  logic [TolW-1:0]  tol_q;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      step_q   <= StepReset;
      tol_q    <= TolReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegTarget: target_q <= cfg_data_i[SecW-1:0];
        RegStep:   step_q   <= cfg_data_i[StepW-1:0];
        RegTol:    tol_q    <= cfg_data_i[TolW-1:0];
        default:   ;
      endcase
    end
  end

  wrf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i(in_data_i.cmd),
    .out_valid_o, .out_ready_i, .sts_i(sts), .ctl_o(ctl)
  );

  wrf_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts), .in_i(in_data_i),
    .target_i(target_q), .step_i(step_q), .tol_i(tol_q), .out_o(out_data_o)
  );
endmodule
`default_nettype wire

>>> rtl/wrf_ram.sv
`default_nettype none
module wrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/wrf_sqrt.sv
`default_nettype none
module wrf_sqrt
  import wrf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SumW-1:0]  rad_i,
  output logic                  done_o,
  output logic [RootW-1:0]      root_o
);
  localparam int unsigned RemW = RootW + 2;
  localparam int unsigned CntW2 = $clog2(RootW + 1);

  logic [2*RootW-1:0] rad_q, rad_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [RootW-1:0]   root_q, root_d;
  logic [CntW2-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [RemW-1:0]    trial;
  logic [RemW-1:0]    rem_sh;

  // One result bit per cycle, restoring method.
  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_sh = {rem_q[RemW-3:0], rad_q[2*RootW-1 -: 2]};
    trial  = {root_q, 2'b01};
    if (start_i) begin
      rad_d  = (2*RootW)'(rad_i);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW2'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[2*RootW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW2'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = busy_q && (cnt_q == CntW2'(1));
  assign root_o = root_d;
endmodule
`default_nettype wire

>>> rtl/wrf_div.sv
`default_nettype none
module wrf_div
  import wrf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [ProdW-1:0] num_i,
  input  wire logic [RootW-1:0] den_i,
  output logic                  done_o,
  output logic [ProdW-1:0]      quo_o
);
  localparam int unsigned CntW2 = $clog2(ProdW + 1);

  logic [ProdW-1:0] num_q, num_d;
  logic [RootW:0]   rem_q, rem_d;
  logic [RootW-1:0] den_q;
  logic [CntW2-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [RootW:0]   rem_sh;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_sh = {rem_q[RootW-1:0], num_q[ProdW-1]};
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW2'(ProdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        num_d = {num_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        num_d = {num_q[ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW2'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = busy_q && (cnt_q == CntW2'(1));
  assign quo_o  = num_d;
endmodule
`default_nettype wire

>>> rtl/wrf_datapath.sv
`default_nettype none
module wrf_datapath
  import wrf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ctl_t       ctl_i,
  output sts_t            sts_o,
  input  wire in_req_t    in_i,
  input  wire logic [SecW-1:0]  target_i,
  input  wire logic [StepW-1:0] step_i,
  input  wire logic [TolW-1:0]  tol_i,
  output out_req_t        out_o
);
  in_req_t               req_q;
  logic [CntW-1:0]       cnt_q [NumSections];
  logic signed [PosW-1:0] rx_q, ry_q;
  logic [SecW-1:0]       cur_sec_q, nxt_sec_q;
  logic [PtW-1:0]        cur_pt_q, nxt_pt_q;
  logic                  moving_q;
  logic signed [PosW-1:0] wx, wy;
  logic signed [PosW:0]  dx_q, dy_q;
  logic [MagW-1:0]       mx, my;
  logic [SumW-1:0]       sum_q;
  logic [2*TolW-1:0]     tol_sq_q;
  logic [ProdW-1:0]      px_q, py_q;
  logic [RootW-1:0]      root, d_q;
  logic                  sq_done, dx_done, dy_done;
  logic [ProdW-1:0]      qx, qy;
  logic [CntW-1:0]       cur_cnt;
  logic                  wrap;
  logic signed [PosW+1:0] sx, sy;
  logic [AddrW-1:0]      raddr;

  assign cur_cnt = cnt_q[cur_sec_q];
  // Current waypoint counts as last once its index plus one reaches the section's count.
  assign wrap = ({1'b0, cur_pt_q} + 1'b1) >= cur_cnt;
  assign sts_o.is_last = wrap && (cur_sec_q == target_i);
  assign raddr = wrap ? {cur_sec_q + 1'b1, {PtW{1'b0}}} : {cur_sec_q, cur_pt_q + 1'b1};

  wrf_ram #(.Width(PosW), .Depth(Depth)) u_ram_x (
    .clk_i, .we_i(ctl_i.do_write), .waddr_i({req_q.section_sel, req_q.point_sel}),
    .wdata_i(req_q.coord_x), .raddr_i(raddr), .rdata_o(wx)
  );
  wrf_ram #(.Width(PosW), .Depth(Depth)) u_ram_y (
    .clk_i, .we_i(ctl_i.do_write), .waddr_i({req_q.section_sel, req_q.point_sel}),
    .wdata_i(req_q.coord_y), .raddr_i(raddr), .rdata_o(wy)
  );

  assign mx = dx_q[PosW] ? MagW'(-dx_q) : MagW'(dx_q);
  assign my = dy_q[PosW] ? MagW'(-dy_q) : MagW'(dy_q);
  assign sts_o.far = sum_q > SumW'(tol_sq_q);

  wrf_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(ctl_i.sqrt_start), .rad_i(sum_q),
    .done_o(sq_done), .root_o(root)
  );
  assign sts_o.sqrt_done = sq_done;

  wrf_div u_div_x (
    .clk_i, .rst_ni, .start_i(ctl_i.div_start), .num_i(px_q), .den_i(d_q),
    .done_o(dx_done), .quo_o(qx)
  );
  wrf_div u_div_y (
    .clk_i, .rst_ni, .start_i(ctl_i.div_start), .num_i(py_q), .den_i(d_q),
    .done_o(dy_done), .quo_o(qy)
  );
  assign sts_o.div_done = dx_done & dy_done;

  // Signed step sums, saturated later.
  always_comb begin
    sx = (PosW+2)'(rx_q) + (dx_q[PosW] ? -(PosW+2)'(qx) : (PosW+2)'(qx));
    sy = (PosW+2)'(ry_q) + (dy_q[PosW] ? -(PosW+2)'(qy) : (PosW+2)'(qy));
  end

  function automatic logic signed [PosW-1:0] sat(input logic signed [PosW+1:0] v);
    logic signed [PosW+1:0] hi, lo;
    hi = (PosW+2)'({1'b0, {(PosW-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) return hi[PosW-1:0];
    if (v < lo) return lo[PosW-1:0];
    return v[PosW-1:0];
  endfunction

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSections; i++) cnt_q[i] <= CntW'(1);
      rx_q      <= '0;
      ry_q      <= '0;
      cur_sec_q <= '0;
      cur_pt_q  <= '0;
      moving_q  <= 1'b0;
    end else begin
      if (ctl_i.load_in) moving_q <= 1'b0;
      if (ctl_i.set_moving) moving_q <= 1'b1;
      if (ctl_i.do_write && req_q.final_point) begin
        cnt_q[req_q.section_sel] <= CntW'(req_q.point_sel) + 1'b1;
      end
      if (ctl_i.do_place) begin
        cur_sec_q <= req_q.section_sel;
        cur_pt_q  <= req_q.point_sel;
        rx_q      <= req_q.coord_x;
        ry_q      <= req_q.coord_y;
      end
      if (ctl_i.adopt) begin
        cur_sec_q <= nxt_sec_q;
        cur_pt_q  <= nxt_pt_q;
      end
      if (ctl_i.do_step) begin
        rx_q <= sat(sx);
        ry_q <= sat(sy);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) req_q <= in_i;
    tol_sq_q <= tol_i * tol_i;
    if (ctl_i.pick_next) begin
      nxt_sec_q <= wrap ? cur_sec_q + 1'b1 : cur_sec_q;
      nxt_pt_q  <= wrap ? '0 : cur_pt_q + 1'b1;
    end
    if (ctl_i.calc_dist) begin
      dx_q <= (PosW+1)'(wx) - (PosW+1)'(rx_q);
      dy_q <= (PosW+1)'(wy) - (PosW+1)'(ry_q);
    end
    sum_q <= SumW'(mx * mx) + SumW'(my * my);
    px_q  <= step_i * mx;
    py_q  <= step_i * my;
    if (sq_done) d_q <= (root == '0) ? RootW'(1) : root;
    if (ctl_i.load_out) begin
      out_o.moving       <= moving_q;
      out_o.pos_x_out    <= rx_q;
      out_o.pos_y_out    <= ry_q;
      out_o.section_out  <= cur_sec_q;
      out_o.waypoint_out <= cur_pt_q;
    end
  end

`ifndef SYNTHESIS
  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[cur_sec_q] != '0) else $error("section count is zero");
  a_div_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dx_done == dy_done) else $error("dividers out of step");
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.do_step |-> d_q != '0) else $error("zero divisor");
`endif
endmodule
`default_nettype wire

>>> rtl/wrf_ctrl.sv
`default_nettype none
module wrf_ctrl
  import wrf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] cmd_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire sts_t       sts_i,
  output ctl_t            ctl_o
);
  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SDecode = 4'd1;
  localparam logic [3:0] SRead  = 4'd2;
  localparam logic [3:0] SDist  = 4'd3;
  localparam logic [3:0] SSum   = 4'd4;
  localparam logic [3:0] SCmp   = 4'd5;
  localparam logic [3:0] SSqrt  = 4'd6;
  localparam logic [3:0] SDivGo = 4'd7;
  localparam logic [3:0] SDiv   = 4'd8;
  localparam logic [3:0] SOut   = 4'd9;
  localparam logic [3:0] SWait  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [1:0] cmd_q;
  logic       ovalid_q, ovalid_d;

  // Input is taken when idle; a finished result may still be waiting.
  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    ctl_o    = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          ctl_o.load_in = 1'b1;
          state_d = SDecode;
        end
      end
      SDecode: begin
        case (cmd_q)
          CmdWrite: begin
            ctl_o.do_write = 1'b1;
            state_d = SOut;
          end
          CmdPlace: begin
            ctl_o.do_place = 1'b1;
            state_d = SOut;
          end
          CmdTick: begin
            if (sts_i.is_last) begin
              state_d = SOut;
            end else begin
              ctl_o.pick_next  = 1'b1;
              ctl_o.set_moving = 1'b1;
              state_d = SRead;
            end
          end
          default: state_d = SOut;
        endcase
      end
      SRead: state_d = SDist;
      SDist: begin
        ctl_o.calc_dist = 1'b1;
        state_d = SSum;
      end
      SSum: state_d = SCmp;
      SCmp: begin
        if (sts_i.far) begin
          ctl_o.sqrt_start = 1'b1;
          state_d = SSqrt;
        end else begin
          ctl_o.adopt = 1'b1;
          state_d = SOut;
        end
      end
      SSqrt: if (sts_i.sqrt_done) state_d = SDivGo;
      SDivGo: begin
        ctl_o.div_start = 1'b1;
        state_d = SDiv;
      end
      SDiv: begin
        if (sts_i.div_done) begin
          ctl_o.do_step = 1'b1;
          state_d = SOut;
        end
      end
      SOut: state_d = SWait;
      SWait: begin
        if (!ovalid_q || out_ready_i) begin
          ctl_o.load_out = 1'b1;
          ovalid_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ovalid_q <= 1'b0;
      cmd_q    <= CmdTick;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (ctl_o.load_in) cmd_q <= cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == SDecode) else $error("request lost");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load_out |-> (!ovalid_q || out_ready_i)) else $error("result overwritten");
  a_step_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.do_step |-> sts_i.div_done) else $error("step before division");
`endif
endmodule
`default_nettype wire
